// ----- rtl/core/sha1s_pkg.sv -----
package sha1s_pkg;

  // round constants, one per group of twenty rounds
  localparam logic [31:0] K_00_19 = 32'h5A827999;
  localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
  localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
  localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

  localparam logic [31:0] H_INIT [0:4] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] FILL_LEN  = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;

  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [6:0] ROUND_G1   = 7'd20;
  localparam logic [6:0] ROUND_G2   = 7'd40;
  localparam logic [6:0] ROUND_G3   = 7'd60;

  localparam logic [2:0] WORD_LAST = 3'd4;

  // source of the byte pushed into the block
  localparam logic [1:0] SRC_INPUT = 2'd0;
  localparam logic [1:0] SRC_MARK  = 2'd1;
  localparam logic [1:0] SRC_ZERO  = 2'd2;
  localparam logic [1:0] SRC_LEN   = 2'd3;

  typedef struct packed {
    logic       push;
    logic [1:0] src;
    logic       step;
    logic       add;
    logic       restart;
    logic [2:0] word_sel;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_at_len;
    logic round_last;
  } stat_t;

endpackage

// ----- rtl/core/sha1s_dp.sv -----
module sha1s_dp
  import sha1s_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [7:0]  data_byte,
  output stat_t       stat,
  output logic [31:0] digest_word
);

  logic [511:0] blk;
  logic [31:0]  chain [0:4];
  logic [31:0]  wa, wb, wc, wd, we;
  logic [6:0]   round;
  logic [5:0]   fill;
  logic [63:0]  message_bits;

  logic [7:0]   byte_in;
  logic [31:0]  w_cur, w_new, w_mix, f, k, tmp;

  function automatic logic [31:0] word_at(input logic [511:0] v, input int i);
    word_at = v[511 - 32*i -: 32];
  endfunction

  always_comb begin
    case (cmd.src)
      SRC_INPUT: byte_in = data_byte;
      SRC_MARK:  byte_in = PAD_MARK;
      SRC_ZERO:  byte_in = 8'h00;
      SRC_LEN:   byte_in = message_bits[63:56];
      default:   byte_in = 8'h00;
    endcase
  end

  // rolling schedule: oldest word at the top of the block register
  assign w_cur = word_at(blk, 0);
  assign w_mix = word_at(blk, 13) ^ word_at(blk, 8) ^ word_at(blk, 2) ^ w_cur;
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    if (round < ROUND_G1) begin
      f = (wb & wc) | (~wb & wd);
      k = K_00_19;
    end else if (round < ROUND_G2) begin
      f = wb ^ wc ^ wd;
      k = K_20_39;
    end else if (round < ROUND_G3) begin
      f = (wb & wc) | (wb & wd) | (wc & wd);
      k = K_40_59;
    end else begin
      f = wb ^ wc ^ wd;
      k = K_60_79;
    end
  end

  assign tmp = {wa[26:0], wa[31:27]} + f + we + k + w_cur;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      blk <= {blk[503:0], byte_in};
    end else if (cmd.step) begin
      blk <= {blk[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) chain[i] <= H_INIT[i];
      wa <= '0;
      wb <= '0;
      wc <= '0;
      wd <= '0;
      we <= '0;
      round <= '0;
      fill <= '0;
      message_bits <= '0;
    end else begin
      if (cmd.push) begin
        fill <= fill + 6'd1;
        if (cmd.src == SRC_INPUT) message_bits <= message_bits + 64'd8;
        if (cmd.src == SRC_LEN) message_bits <= {message_bits[55:0], 8'h00};
        // block complete: load working words for the compression
        if (fill == FILL_LAST) begin
          wa <= chain[0];
          wb <= chain[1];
          wc <= chain[2];
          wd <= chain[3];
          we <= chain[4];
          round <= '0;
        end
      end
      if (cmd.step) begin
        wa <= tmp;
        wb <= wa;
        wc <= {wb[1:0], wb[31:2]};
        wd <= wc;
        we <= wd;
        round <= round + 7'd1;
      end
      if (cmd.add) begin
        chain[0] <= chain[0] + wa;
        chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc;
        chain[3] <= chain[3] + wd;
        chain[4] <= chain[4] + we;
      end
      if (cmd.restart) begin
        for (int i = 0; i < 5; i++) chain[i] <= H_INIT[i];
        message_bits <= '0;
      end
    end
  end

  assign stat.fill_last   = (fill == FILL_LAST);
  assign stat.fill_at_len = (fill == FILL_LEN);
  assign stat.round_last  = (round == ROUND_LAST);

  always_comb begin
    case (cmd.word_sel)
      3'd0:    digest_word = chain[0];
      3'd1:    digest_word = chain[1];
      3'd2:    digest_word = chain[2];
      3'd3:    digest_word = chain[3];
      3'd4:    digest_word = chain[4];
      default: digest_word = '0;
    endcase
  end

endmodule

// ----- rtl/core/sha1s_ctrl.sv -----
module sha1s_ctrl
  import sha1s_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       byte_present,
  input  logic       end_of_message,
  input  logic       out_stall,
  input  stat_t      stat,
  output cmd_t       cmd,
  output logic       in_stall,
  output logic       out_valid,
  output logic [2:0] word_index,
  output logic       last_word
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PAD80  = 3'd1;
  localparam logic [2:0] S_PADZ   = 3'd2;
  localparam logic [2:0] S_PADLEN = 3'd3;
  localparam logic [2:0] S_COMP   = 3'd4;
  localparam logic [2:0] S_ADD    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state, state_next;
  logic [2:0] ret, ret_next;
  logic [2:0] idx, idx_next;

  always_comb begin
    state_next = state;
    ret_next = ret;
    idx_next = idx;
    cmd = '0;
    cmd.word_sel = idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (byte_present) begin
            cmd.push = 1'b1;
            cmd.src = SRC_INPUT;
            if (stat.fill_last) begin
              state_next = S_COMP;
              ret_next = end_of_message ? S_PAD80 : S_IDLE;
            end else if (end_of_message) begin
              state_next = S_PAD80;
            end
          end else if (end_of_message) begin
            state_next = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        cmd.push = 1'b1;
        cmd.src = SRC_MARK;
        if (stat.fill_last) begin
          state_next = S_COMP;
          ret_next = S_PADZ;
        end else begin
          state_next = S_PADZ;
        end
      end
      S_PADZ: begin
        if (stat.fill_at_len) begin
          state_next = S_PADLEN;
        end else begin
          cmd.push = 1'b1;
          cmd.src = SRC_ZERO;
          if (stat.fill_last) begin
            state_next = S_COMP;
            ret_next = S_PADZ;
          end
        end
      end
      S_PADLEN: begin
        // length bytes fill positions 56 to 63, the last one closes the block
        cmd.push = 1'b1;
        cmd.src = SRC_LEN;
        if (stat.fill_last) begin
          state_next = S_COMP;
          ret_next = S_OUT;
        end
      end
      S_COMP: begin
        cmd.step = 1'b1;
        if (stat.round_last) state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        state_next = ret;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (idx == WORD_LAST) begin
            cmd.restart = 1'b1;
            idx_next = '0;
            state_next = S_IDLE;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      idx <= '0;
    end else begin
      state <= state_next;
      ret <= ret_next;
      idx <= idx_next;
    end
  end

  assign in_stall   = (state != S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign word_index = idx;
  assign last_word  = (idx == WORD_LAST);

endmodule

// ----- rtl/core/sha1_stream_hasher.sv -----
// SHA-1 hasher over a byte stream. One request carries at most one message
// byte and an end-of-message mark; a request with the mark (with or without a
// byte) pads the message and returns the 160-bit digest as five 32-bit words,
// H0 first, after which the hasher is ready for the next message. A byte that
// does not complete a 64-byte block is taken without stalling the input. A byte
// that completes a block starts the compression, one round per cycle over 80
// rounds, after which the result is folded into the chaining words, with the
// input stalled throughout. Finishing a message pushes the padding bytes (up to
// 72, the length bytes included) one at a time, passes through an idle step at
// the start of the length field, compresses each of the one or two padding
// blocks and then hands out the digest words; no request is taken until the
// last word has gone. On long messages the hasher takes no new byte while a
// block is being compressed.
module sha1_stream_hasher
  import sha1s_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  cmd_t  cmd;
  stat_t stat;

  sha1s_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .out_stall      (out_stall),
    .stat           (stat),
    .cmd            (cmd),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .word_index     (word_index),
    .last_word      (last_word)
  );

  sha1s_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .stat        (stat),
    .digest_word (digest_word)
  );

endmodule

// ----- rtl/core/sha1s_checker.sv -----
module sha1s_checker
  import sha1s_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  // a stalled digest word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digest_word) && $stable(word_index))
    else $error("digest word changed while stalled");

  // no request is taken while the digest is being handed out
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request taken during digest output");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == WORD_LAST)))
    else $error("last word flag does not match index");

  // words of one digest follow in order without a gap
  a_word_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_word |=>
      out_valid && (word_index == $past(word_index) + 3'd1))
    else $error("digest words out of sequence");

  a_first_word: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (word_index == 3'd0))
    else $error("digest does not start with the first word");

endmodule

bind sha1_stream_hasher sha1s_checker u_sha1s_checker (.*);
